### rtl/core/ngr_pkg.sv
// Package for the NMEA GGA/RMC parser: payload types, character codes,
// sentence kinds and the reciprocal constants used by the decode sequencer.
// No dependencies.
package ngr_pkg;

  typedef struct packed {
    logic [7:0] char_in;
  } in_t;

  typedef struct packed {
    logic               frame_ok;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic               fix_valid;
    logic [7:0]         sat_count;
    logic signed [15:0] altitude_m;
    logic [15:0]        speed_cm_s;
    logic [15:0]        course_decideg;
  } out_t;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_GGA  = 2'd1;
  localparam logic [1:0] KIND_RMC  = 2'd2;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;

  // floor(x/6) = (x*M_DIV6)>>31 for x < 2^28
  localparam logic [28:0] M_DIV6     = 29'd357913942;
  localparam int          SH_DIV6    = 31;
  // floor(x/1000) = (x*M_DIV1000)>>39 for x < 2^29
  localparam logic [29:0] M_DIV1000  = 30'd549755814;
  localparam int          SH_DIV1000 = 39;
  localparam logic [12:0] KNOT_CM    = 13'd5144;
  localparam logic [19:0] MIN_SCALE  = 20'd1000000;
  localparam logic [23:0] DEG_SCALE  = 24'd10000000;

endpackage

### rtl/core/ngr_stream_if.sv
// Valid/ready stream interface carrying one payload struct per transaction.
// Payload type comes from ngr_pkg at the instance.
interface ngr_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/core/nmea_gga_rmc_parser.sv
// NMEA GGA/RMC sentence parser, top level.
// Depends on ngr_pkg, ngr_stream_if and ngr_mac.
//
// Usage: one NMEA character per transaction on chars; every character gives
// exactly one transaction on results carrying the current decoded position,
// fix, satellites, altitude, speed and course, plus frame_ok on a CR/LF that
// closes a GGA sentence with a matching checksum.
// Ordinary characters, '$' and CR/LF give their result in the cycle after
// acceptance. A ',' or '*' goes through the dispatch state, which may start
// a field decode on the shared multiply-by-ten accumulator, one buffer
// character per cycle; speed adds a knots multiply and a divide by 1000,
// coordinates scan, then degrees, minutes, fraction, combine, divide by 6.
// chars.ready is low while a decode runs and while a result waits that the
// receiver does not take in the same cycle; a stalled receiver holds the
// block. Reset (synchronous, active high) clears all state and the field
// buffer and drops any pending result.
module nmea_gga_rmc_parser #(
  parameter int FIELD_CHARS = 15,
  parameter int FRAC_DIGITS = 4
) (
  input logic         clk,
  input logic         rst,
  ngr_stream_if.sink   chars,
  ngr_stream_if.source results
);
  import ngr_pkg::*;

  localparam int BUF_LEN = FIELD_CHARS + 1;
  localparam int IW      = $clog2(BUF_LEN);
  localparam int PW      = $clog2(BUF_LEN + 1);
  localparam int KW      = $clog2(FRAC_DIGITS + 1);
  localparam int SCALE   = 1000000 / (10 ** FRAC_DIGITS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_NUM    = 4'd2;
  localparam logic [3:0] S_NUMDOT = 4'd3;
  localparam logic [3:0] S_SPD1   = 4'd4;
  localparam logic [3:0] S_SPD2   = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_DEG    = 4'd7;
  localparam logic [3:0] S_MIN    = 4'd8;
  localparam logic [3:0] S_FRAC   = 4'd9;
  localparam logic [3:0] S_CMB1   = 4'd10;
  localparam logic [3:0] S_CMB2   = 4'd11;
  localparam logic [3:0] S_DIV    = 4'd12;
  localparam logic [3:0] S_FIN    = 4'd13;

  localparam logic [2:0] D_SATS = 3'd0;
  localparam logic [2:0] D_ALT  = 3'd1;
  localparam logic [2:0] D_SPD  = 3'd2;
  localparam logic [2:0] D_CRS  = 3'd3;
  localparam logic [2:0] D_LAT  = 3'd4;
  localparam logic [2:0] D_LON  = 3'd5;

  logic [3:0]  state;
  logic [7:0]  field_index;
  logic [4:0]  char_count;
  logic [7:0]  running_parity;
  logic        checksum_pending;
  logic [1:0]  sentence_kind;
  logic [7:0]  field_chars [BUF_LEN];
  logic [31:0] lat_reg, lon_reg;
  logic        fix_reg;
  logic [7:0]  sats_reg;
  logic [15:0] alt_reg, speed_reg, course_reg;

  logic [PW-1:0] ptr, pend;
  logic [KW-1:0] kcnt;
  logic [31:0]   acc, prod;
  logic [7:0]    deg, mins;
  logic [2:0]    dest;
  logic          one_dec;
  logic          out_valid, frame_ok_r;

  logic        accept, ptr_in, is_digit, num_end;
  logic [7:0]  ch, c, hv0, hv1, sum;
  logic [31:0] mac_out, num_val;
  logic [56:0] p6;
  logic [58:0] p1k;

  ngr_mac u_mac (.acc(acc), .ch(ch), .result(mac_out));

  function automatic logic [3:0] hex_val(input logic [7:0] n);
    logic [7:0] t;
    t = n - CH_ZERO;
    if (t > 8'd9) t = t - 8'd7;
    return t[3:0];
  endfunction

  assign chars.ready = (state == S_IDLE) && (!out_valid || results.ready);
  assign accept      = chars.valid && chars.ready;
  assign c           = chars.data.char_in;

  always_comb begin
    ptr_in   = ptr < PW'(BUF_LEN);
    ch       = ptr_in ? field_chars[ptr[IW-1:0]] : 8'd0;
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    num_end  = !ptr_in || (ch == 8'd0) || (ch == CH_DOT && !one_dec);
    num_val  = (state == S_NUMDOT) ? mac_out : acc;
    hv0      = {4'd0, hex_val(field_chars[0])};
    hv1      = {4'd0, hex_val(field_chars[1])};
    sum      = (hv0 << 4) + hv1;
    p6       = 57'(prod[27:0]) * 57'(M_DIV6);
    p1k      = 59'(prod[28:0]) * 59'(M_DIV1000);
  end

  assign results.valid               = out_valid;
  assign results.data.frame_ok       = frame_ok_r;
  assign results.data.latitude       = lat_reg;
  assign results.data.longitude      = lon_reg;
  assign results.data.fix_valid      = fix_reg;
  assign results.data.sat_count      = sats_reg;
  assign results.data.altitude_m     = alt_reg;
  assign results.data.speed_cm_s     = speed_reg;
  assign results.data.course_decideg = course_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      field_index      <= '0;
      char_count       <= '0;
      running_parity   <= '0;
      checksum_pending <= 1'b0;
      sentence_kind    <= KIND_NONE;
      for (int i = 0; i < BUF_LEN; i++) field_chars[i] <= '0;
      lat_reg    <= '0;
      lon_reg    <= '0;
      fix_reg    <= 1'b0;
      sats_reg   <= '0;
      alt_reg    <= '0;
      speed_reg  <= '0;
      course_reg <= '0;
      out_valid  <= 1'b0;
      frame_ok_r <= 1'b0;
      ptr <= '0; pend <= '0; kcnt <= '0; acc <= '0; prod <= '0;
      deg <= '0; mins <= '0; dest <= D_SATS; one_dec <= 1'b0;
    end else begin
      if (out_valid && results.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            frame_ok_r <= 1'b0;
            if (c == CH_DOLLAR) begin
              field_index    <= '0;
              char_count     <= '0;
              running_parity <= '0;
              out_valid      <= 1'b1;
            end else if (c == CH_COMMA || c == CH_STAR) begin
              if (6'(char_count) < 6'(BUF_LEN)) field_chars[char_count[IW-1:0]] <= 8'd0;
              char_count <= '0;
              if (c == CH_STAR) checksum_pending <= 1'b1;
              else running_parity <= running_parity ^ c;
              state <= S_DISP;
            end else if (c == CH_CR || c == CH_LF) begin
              frame_ok_r <= checksum_pending && (sum == running_parity) &&
                            (sentence_kind == KIND_GGA);
              checksum_pending <= 1'b0;
              out_valid        <= 1'b1;
            end else begin
              if (6'(char_count) < 6'(FIELD_CHARS)) begin
                field_chars[char_count[IW-1:0]] <= c;
                char_count <= char_count + 5'd1;
              end
              if (!checksum_pending) running_parity <= running_parity ^ c;
              out_valid <= 1'b1;
            end
          end
        end
        S_DISP: begin
          ptr   <= '0;
          acc   <= '0;
          state <= S_IDLE;
          if (field_index == 8'd0) begin
            sentence_kind <= KIND_NONE;
            if (field_chars[0] == CH_G && (field_chars[1] == CH_N || field_chars[1] == CH_P)) begin
              if (field_chars[2] == CH_G && field_chars[3] == CH_G && field_chars[4] == CH_A)
                sentence_kind <= KIND_GGA;
              if (field_chars[2] == CH_R && field_chars[3] == CH_M && field_chars[4] == CH_C)
                sentence_kind <= KIND_RMC;
            end
          end else if (sentence_kind == KIND_GGA) begin
            case (field_index)
              8'd2: begin dest <= D_LAT; state <= S_SCAN; end
              8'd3: if (field_chars[0] == CH_S) lat_reg <= 32'd0 - lat_reg;
              8'd4: begin dest <= D_LON; state <= S_SCAN; end
              8'd5: if (field_chars[0] == CH_W) lon_reg <= 32'd0 - lon_reg;
              8'd6: fix_reg <= (field_chars[0] > CH_ZERO) && !field_chars[0][7];
              8'd7: begin dest <= D_SATS; one_dec <= 1'b0; state <= S_NUM; end
              8'd9: begin dest <= D_ALT; one_dec <= 1'b0; state <= S_NUM; end
              default: ;
            endcase
          end else if (sentence_kind == KIND_RMC) begin
            if (field_index == 8'd7) begin
              dest <= D_SPD; one_dec <= 1'b1; state <= S_NUM;
            end else if (field_index == 8'd8) begin
              dest <= D_CRS; one_dec <= 1'b1; state <= S_NUM;
            end
          end
          if (state == S_DISP && !((field_index != 8'd0) &&
              ((sentence_kind == KIND_GGA && (field_index == 8'd2 || field_index == 8'd4 ||
                field_index == 8'd7 || field_index == 8'd9)) ||
               (sentence_kind == KIND_RMC && (field_index == 8'd7 || field_index == 8'd8))))) begin
            field_index <= field_index + 8'd1;
            out_valid   <= 1'b1;
          end
        end
        S_NUM, S_NUMDOT: begin
          if (state == S_NUM && !num_end && ch == CH_DOT) begin
            ptr   <= ptr + PW'(1);
            state <= S_NUMDOT;
          end else if (state == S_NUM && !num_end) begin
            acc <= mac_out;
            ptr <= ptr + PW'(1);
          end else begin
            acc   <= num_val;
            state <= S_IDLE;
            case (dest)
              D_SATS: sats_reg   <= num_val[7:0];
              D_ALT:  alt_reg    <= num_val[15:0];
              D_CRS:  course_reg <= num_val[15:0];
              default: state <= S_SPD1;
            endcase
            if (dest != D_SPD) begin
              field_index <= field_index + 8'd1;
              out_valid   <= 1'b1;
            end
          end
        end
        S_SPD1: begin
          prod  <= 32'(48'(acc[15:0]) * 48'(KNOT_CM));
          state <= S_SPD2;
        end
        S_SPD2: begin
          speed_reg   <= p1k[SH_DIV1000+15:SH_DIV1000];
          field_index <= field_index + 8'd1;
          out_valid   <= 1'b1;
          state       <= S_IDLE;
        end
        S_SCAN: begin
          if (ptr_in && is_digit) begin
            ptr <= ptr + PW'(1);
          end else begin
            pend  <= ptr;
            ptr   <= '0;
            acc   <= '0;
            state <= S_DEG;
          end
        end
        S_DEG: begin
          if ((pend - ptr) > PW'(2)) begin
            acc <= mac_out;
            ptr <= ptr + PW'(1);
          end else begin
            deg   <= acc[7:0];
            acc   <= '0;
            state <= S_MIN;
          end
        end
        S_MIN: begin
          if (ptr < pend) begin
            acc <= mac_out;
            ptr <= ptr + PW'(1);
          end else begin
            mins <= acc[7:0];
            acc  <= '0;
            kcnt <= '0;
            // ptr sits on the character after the integer digits
            if (ch == CH_DOT) begin
              ptr   <= ptr + PW'(1);
              state <= S_FRAC;
            end else begin
              state <= S_CMB1;
            end
          end
        end
        S_FRAC: begin
          acc <= mac_out;
          if (is_digit) ptr <= ptr + PW'(1);
          kcnt <= kcnt + KW'(1);
          if (kcnt == KW'(FRAC_DIGITS - 1)) state <= S_CMB1;
        end
        S_CMB1: begin
          prod  <= 32'(40'(acc[19:0]) * 40'(SCALE));
          state <= S_CMB2;
        end
        S_CMB2: begin
          prod  <= 32'(36'(mins) * 36'(MIN_SCALE) + 36'(prod));
          state <= S_DIV;
        end
        S_DIV: begin
          prod  <= 32'(p6 >> SH_DIV6);
          state <= S_FIN;
        end
        S_FIN: begin
          if (dest == D_LAT) lat_reg <= 32'(40'(deg) * 40'(DEG_SCALE)) + prod;
          else lon_reg <= 32'(40'(deg) * 40'(DEG_SCALE)) + prod;
          field_index <= field_index + 8'd1;
          out_valid   <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/core/ngr_mac.sv
// Shared decimal accumulate unit: acc*10 plus the digit value of ch
// (non-digits add zero). Uses ngr_pkg character codes.
module ngr_mac (
  input  logic [31:0] acc,
  input  logic [7:0]  ch,
  output logic [31:0] result
);
  import ngr_pkg::*;

  logic       digit;
  logic [7:0] dv;

  always_comb begin
    digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    dv     = digit ? (ch - CH_ZERO) : 8'd0;
    result = (acc << 3) + (acc << 1) + {28'd0, dv[3:0]};
  end
endmodule
